@@ sv/pfts_pkg.sv @@
// pfts_pkg: shared types and constants for the task scheduler
// no dependencies
`default_nettype none
package pfts_pkg;
  typedef enum logic [2:0] {
    OP_CREATE = 3'd0, OP_PICK = 3'd1, OP_YIELD = 3'd2, OP_SLEEP = 3'd3,
    OP_WAKEUP = 3'd4, OP_KILL = 3'd5, OP_EXIT = 3'd6, OP_REMOVE = 3'd7
  } op_t;
  typedef enum logic [2:0] {
    ST_FREE = 3'd0, ST_RUNNABLE = 3'd1, ST_RUNNING = 3'd2,
    ST_SLEEPING = 3'd3, ST_ZOMBIE = 3'd4
  } tstat_t;
  typedef enum logic [2:0] {
    S_IDLE, S_CLEAR, S_SCAN, S_APPLY, S_GAP, S_OUT
  } fsm_t;
  localparam int SLOTS = 64;
  localparam int PID_W = 31;
  localparam int TAG_W = 32;
  localparam int SLOT_W = 6;
  localparam int PRIO_W = 4;
  // one task table entry, all fields that the sweeps walk
  typedef struct packed {
    tstat_t            st;
    logic [PRIO_W-1:0] prio;
    logic [SLOT_W-1:0] rank;
    logic              killed;
  } tent_t;
endpackage
`default_nettype wire

@@ sv/pfts_scan.sv @@
// pfts_scan: shared compare unit, evaluates one table entry per cycle while step is high
// depends on pfts_pkg
`default_nettype none
module pfts_scan import pfts_pkg::*; #(
  parameter int IDX_W = 6,
  parameter int RANK_W = 6
) (
  input  wire logic             clk,
  input  wire logic             start,
  input  wire logic             step,
  input  wire op_t              op,
  input  wire logic [IDX_W-1:0] idx,
  input  wire tstat_t           st,
  input  wire logic [PRIO_W-1:0] prio,
  input  wire logic [RANK_W-1:0] rank,
  input  wire logic [PID_W-1:0] pid,
  input  wire logic [PID_W-1:0] tpid,
  output logic                  found_r,
  output logic [IDX_W-1:0]      best_r
);
  logic [PRIO_W-1:0] bprio_r;
  logic [RANK_W-1:0] brank_r;
  logic hit;
  logic better;

  always_comb begin
    hit = 1'b0;
    better = 1'b0;
    case (op)
      OP_CREATE: begin
        hit = (st == ST_FREE);
        better = hit && !found_r;
      end
      OP_PICK: begin
        hit = (st == ST_RUNNABLE);
        better = hit && (!found_r || prio < bprio_r ||
                 (prio == bprio_r && rank < brank_r));
      end
      OP_KILL: begin
        hit = (st != ST_FREE) && (pid == tpid);
        better = hit && (!found_r || rank < brank_r);
      end
      default: begin
        hit = 1'b0;
        better = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (start) begin
      found_r <= 1'b0;
      best_r <= '0;
    end else if (step && better) begin
      found_r <= 1'b1;
      best_r <= idx;
      bprio_r <= prio;
      brank_r <= rank;
    end
  end
endmodule
`default_nettype wire

@@ sv/priority_fcfs_task_scheduler.sv @@
// priority_fcfs_task_scheduler: task table with multilevel priority pick
// depends on pfts_pkg, pfts_scan
//
// channel | ports                                   | dir
// in      | in_valid in_ready in_op in_slot in_wait_tag in_target_pid | in
// out     | out_valid out_ready out_ok out_result_slot out_result_pid out_killed_flag | out
//
// a sweep reads one entry per cycle through the registered table port
// create, pick, kill, wakeup: a full sweep in S_SCAN, then S_APPLY and S_OUT to out_valid
// yield, sleep, exit, remove: a rank gap pass (S_GAP) after S_SCAN unless in the wrong state
// the single entry table read port and the compare unit set the sweep length
// after reset the entry table is cleared entry by entry in S_CLEAR before in_ready rises
// a result waiting on out_ready holds off the next transaction
`default_nettype none
module priority_fcfs_task_scheduler import pfts_pkg::*; #(
  parameter int LOWEST_PRIORITY = 5
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [2:0]        in_op,
  input  wire logic [SLOT_W-1:0] in_slot,
  input  wire logic [TAG_W-1:0]  in_wait_tag,
  input  wire logic [PID_W-1:0]  in_target_pid,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_ok,
  output logic [SLOT_W-1:0]      out_result_slot,
  output logic [PID_W-1:0]       out_result_pid,
  output logic                   out_killed_flag
);
  localparam int IDX_W = SLOT_W;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam logic [PRIO_W-1:0] LOWP = PRIO_W'(LOWEST_PRIORITY);

  tent_t            ent_mem [SLOTS];
  logic [PID_W-1:0] pid_mem [SLOTS];
  logic [TAG_W-1:0] tag_mem [SLOTS];

  logic [CNT_W-1:0] live_r;
  logic [PID_W-1:0] next_pid_r;
  fsm_t state_r, state_nxt;
  op_t op_r;
  logic [SLOT_W-1:0] slot_r;
  logic [TAG_W-1:0] tag_r;
  logic [PID_W-1:0] tpid_r;
  logic [CNT_W-1:0] cnt_r;
  logic [IDX_W-1:0] gap_slot_r, gap_rank_r;
  logic wake_r;
  tent_t tgt_r;
  logic need_r;

  // registered reads of the entry table and the pid and tag rams
  tent_t ent_rd_r;
  logic [PID_W-1:0] pid_rd_r;
  logic [TAG_W-1:0] tag_rd_r;
  logic [IDX_W-1:0] idx_d_r;
  logic rd_v_r;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] rd_addr;
  logic [PID_W-1:0] rpid_rd_r;

  logic ent_we;
  logic [IDX_W-1:0] ent_wa;
  tent_t ent_wd;

  logic found, scan_start;
  logic [IDX_W-1:0] best;
  logic in_range;
  logic [IDX_W-1:0] sl;
  logic need_gap;
  logic scan_done;
  logic sweeping;
  logic wake_hit;

  logic res_ok;
  logic [SLOT_W-1:0] res_slot;
  logic [PID_W-1:0] res_pid;
  logic res_kill;

  assign idx = cnt_r[IDX_W-1:0];
  assign in_range = ({{(32-SLOT_W){1'b0}}, slot_r} < 32'(SLOTS));
  assign sl = IDX_W'(slot_r);

  assign in_ready = (state_r == S_IDLE) && !out_valid;
  assign scan_start = in_valid && in_ready;

  pfts_scan #(.IDX_W(IDX_W), .RANK_W(IDX_W)) u_scan (
    .clk(clk), .start(scan_start), .step(rd_v_r), .op(op_r), .idx(idx_d_r),
    .st(ent_rd_r.st), .prio(ent_rd_r.prio), .rank(ent_rd_r.rank),
    .pid(pid_rd_r), .tpid(tpid_r), .found_r(found), .best_r(best)
  );

  // valid in the first scan cycle of a slot operation, entry of the addressed slot
  always_comb begin
    need_gap = 1'b0;
    case (op_r)
      OP_YIELD, OP_SLEEP, OP_EXIT:
        need_gap = in_range && ent_rd_r.st == ST_RUNNING;
      OP_REMOVE: need_gap = in_range && ent_rd_r.st != ST_FREE;
      default: need_gap = 1'b0;
    endcase
  end

  assign scan_done = (cnt_r == CNT_W'(SLOTS)) && !rd_v_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (cnt_r == CNT_W'(SLOTS - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (scan_start) state_nxt = S_SCAN;
      S_SCAN: begin
        if (op_r inside {OP_CREATE, OP_PICK, OP_KILL, OP_WAKEUP}) begin
          if (scan_done) state_nxt = S_APPLY;
        end else if (need_gap) begin
          state_nxt = S_GAP;
        end else begin
          state_nxt = S_APPLY;
        end
      end
      S_GAP:   if (scan_done) state_nxt = S_APPLY;
      S_APPLY: state_nxt = S_OUT;
      S_OUT:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // sweep counter and pipelined read
  always_comb begin
    sweeping = 1'b0;
    case (state_r)
      S_SCAN: sweeping = op_r inside {OP_CREATE, OP_PICK, OP_KILL, OP_WAKEUP};
      S_GAP:  sweeping = 1'b1;
      default: sweeping = 1'b0;
    endcase
  end

  // addressed slot at accept, winner once the sweep is over, else the sweep index
  always_comb begin
    if (state_r == S_IDLE) rd_addr = IDX_W'(in_slot);
    else if (scan_done) rd_addr = best;
    else rd_addr = idx;
  end

  assign wake_hit = (state_r == S_SCAN) && (op_r == OP_WAKEUP) && rd_v_r &&
                    (slot_r != SLOT_W'(idx_d_r) || !in_range) &&
                    ent_rd_r.st == ST_SLEEPING && tag_rd_r == tag_r;

  always_ff @(posedge clk) begin
    ent_rd_r <= ent_mem[rd_addr];
    pid_rd_r <= pid_mem[idx];
    tag_rd_r <= tag_mem[idx];
    idx_d_r <= idx;
    rpid_rd_r <= pid_mem[best];
  end

  // single write port of the entry table
  always_comb begin
    ent_we = 1'b0;
    ent_wa = idx_d_r;
    ent_wd = ent_rd_r;
    case (state_r)
      S_CLEAR: begin
        ent_we = 1'b1;
        ent_wa = idx;
        ent_wd = '0;
      end
      S_SCAN: if (wake_hit) begin
        ent_we = 1'b1;
        ent_wd.st = ST_RUNNABLE;
      end
      // gap closing, one entry per cycle
      S_GAP: if (rd_v_r && idx_d_r != gap_slot_r && ent_rd_r.st != ST_FREE &&
                 ent_rd_r.rank > gap_rank_r) begin
        ent_we = 1'b1;
        ent_wd.rank = ent_rd_r.rank - 1'b1;
      end
      S_APPLY: begin
        case (op_r)
          OP_CREATE: if (found) begin
            ent_we = 1'b1;
            ent_wa = best;
            ent_wd.st = ST_RUNNABLE;
            ent_wd.prio = '0;
            ent_wd.rank = IDX_W'(live_r);
            ent_wd.killed = 1'b0;
          end
          OP_PICK: if (found) begin
            ent_we = 1'b1;
            ent_wa = best;
            ent_wd.st = ST_RUNNING;
          end
          OP_KILL: if (found) begin
            ent_we = 1'b1;
            ent_wa = best;
            ent_wd.killed = 1'b1;
            if (ent_rd_r.st == ST_SLEEPING) ent_wd.st = ST_RUNNABLE;
          end
          OP_WAKEUP: ent_we = 1'b0;
          OP_REMOVE: if (need_r) begin
            ent_we = 1'b1;
            ent_wa = sl;
            ent_wd = '0;
          end
          default: if (need_r) begin
            ent_we = 1'b1;
            ent_wa = sl;
            ent_wd = tgt_r;
            if (op_r == OP_YIELD) begin
              if (tgt_r.prio < LOWP) ent_wd.prio = tgt_r.prio + 1'b1;
              else ent_wd.prio = LOWP;
              ent_wd.st = ST_RUNNABLE;
            end else if (op_r == OP_SLEEP) begin
              ent_wd.st = ST_SLEEPING;
            end else begin
              ent_wd.st = ST_ZOMBIE;
            end
            ent_wd.rank = IDX_W'(live_r - 1'b1);
          end
        endcase
      end
      default: ent_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[ent_wa] <= ent_wd;
  end

  always_comb begin
    res_ok = 1'b0;
    res_slot = '0;
    res_pid = '0;
    res_kill = 1'b0;
    case (op_r)
      OP_CREATE: if (found) begin
        res_ok = 1'b1;
        res_slot = SLOT_W'(best);
        res_pid = next_pid_r;
      end
      OP_PICK: if (found) begin
        res_ok = 1'b1;
        res_slot = SLOT_W'(best);
        res_pid = rpid_rd_r;
        res_kill = ent_rd_r.killed;
      end
      OP_KILL: if (found) begin
        res_ok = 1'b1;
        res_slot = SLOT_W'(best);
        res_pid = rpid_rd_r;
        res_kill = 1'b1;
      end
      OP_WAKEUP: res_ok = wake_r;
      default: if (need_r) begin
        res_ok = 1'b1;
        res_slot = slot_r;
        res_kill = tgt_r.killed;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cnt_r <= '0;
      rd_v_r <= 1'b0;
      live_r <= '0;
      next_pid_r <= PID_W'(1);
      out_valid <= 1'b0;
      wake_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_v_r <= sweeping && cnt_r < CNT_W'(SLOTS);
      if (scan_start) begin
        op_r <= op_t'(in_op);
        slot_r <= in_slot;
        tag_r <= in_wait_tag;
        tpid_r <= in_target_pid;
        cnt_r <= '0;
      end else if (state_r == S_SCAN && !sweeping) begin
        cnt_r <= '0;
      end else if (state_r == S_CLEAR || (sweeping && cnt_r < CNT_W'(SLOTS))) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (state_r == S_SCAN && !sweeping) begin
        gap_slot_r <= sl;
        gap_rank_r <= ent_rd_r.rank;
        tgt_r <= ent_rd_r;
        need_r <= need_gap;
      end
      if (scan_start) wake_r <= 1'b0;
      else if (wake_hit) wake_r <= 1'b1;
      if (state_r == S_APPLY) begin
        out_ok <= res_ok;
        out_result_slot <= res_slot;
        out_result_pid <= res_pid;
        out_killed_flag <= res_kill;
        if (op_r == OP_CREATE && found) begin
          live_r <= live_r + 1'b1;
          next_pid_r <= next_pid_r + 1'b1;
        end else if (op_r == OP_REMOVE && need_r) begin
          live_r <= live_r - 1'b1;
        end
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      else if (state_r == S_OUT) out_valid <= 1'b1;
    end
  end

  // ram writes: pid on create, tag on sleep
  always_ff @(posedge clk) begin
    if (state_r == S_APPLY && op_r == OP_CREATE && found)
      pid_mem[best] <= next_pid_r;
    if (state_r == S_APPLY && op_r == OP_SLEEP && need_r)
      tag_mem[sl] <= tag_r;
  end

`ifndef NO_ASSERTIONS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == S_IDLE) else $error("ready outside idle");
  a_out_after: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r) == S_OUT) else $error("stray result");
  a_live: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= CNT_W'(SLOTS)) else $error("live count overflow");
`endif
endmodule
`default_nettype wire

@@ dv/testbench.sv @@
// testbench for priority_fcfs_task_scheduler: directed and random event streams
// checked against an in-bench task table predictor; depends on pfts_pkg and the rtl
`default_nettype none
module testbench import pfts_pkg::*;;

  localparam int NSLOT = 64;
  localparam int PRIO_MAX = 5;

  typedef struct {
    bit        ok;
    bit [5:0]  slot;
    bit [30:0] pid;
    bit        killed;
  } sched_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_op = '0;
  logic [SLOT_W-1:0] in_slot = '0;
  logic [TAG_W-1:0] in_wait_tag = '0;
  logic [PID_W-1:0] in_target_pid = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_ok;
  logic [SLOT_W-1:0] out_result_slot;
  logic [PID_W-1:0] out_result_pid;
  logic out_killed_flag;

  priority_fcfs_task_scheduler dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op), .in_slot(in_slot),
    .in_wait_tag(in_wait_tag), .in_target_pid(in_target_pid),
    .out_valid(out_valid), .out_ready(out_ready), .out_ok(out_ok),
    .out_result_slot(out_result_slot), .out_result_pid(out_result_pid),
    .out_killed_flag(out_killed_flag)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow task table
  tstat_t    tbl_status[NSLOT];
  int        tbl_prio[NSLOT];
  int        tbl_rank[NSLOT];
  bit [30:0] tbl_pid[NSLOT];
  bit [31:0] tbl_tag[NSLOT];
  bit        tbl_killed[NSLOT];
  int        live_tasks;
  bit [30:0] pid_counter;

  sched_result_t pending_results[$];
  int errors = 0;
  int checked = 0;
  int sent = 0;
  int op_hits[8];
  bit idle_en = 1'b0;
  bit stall_en = 1'b0;
  int stall_left = 0;
  bit [31:0] tag_pool[4];

  function automatic void close_gap(int s);
    for (int t = 0; t < NSLOT; t++)
      if (t != s && tbl_status[t] != ST_FREE && tbl_rank[t] > tbl_rank[s])
        tbl_rank[t]--;
  endfunction

  function automatic sched_result_t schedule_event(op_t op, int s, bit [31:0] tag,
                                                   bit [30:0] tpid);
    sched_result_t r;
    int best;
    r = '{default: 0};
    best = -1;
    case (op)
      OP_CREATE: begin
        for (int i = 0; i < NSLOT; i++)
          if (best < 0 && tbl_status[i] == ST_FREE) best = i;
        if (best >= 0) begin
          tbl_status[best] = ST_RUNNABLE;
          tbl_prio[best] = 0;
          tbl_killed[best] = 0;
          tbl_pid[best] = pid_counter;
          pid_counter = pid_counter + 31'd1;
          live_tasks++;
          tbl_rank[best] = live_tasks - 1;
          r.ok = 1; r.slot = 6'(best); r.pid = tbl_pid[best];
        end
      end
      OP_PICK: begin
        for (int i = 0; i < NSLOT; i++)
          if (tbl_status[i] == ST_RUNNABLE &&
              (best < 0 || tbl_prio[i] < tbl_prio[best] ||
               (tbl_prio[i] == tbl_prio[best] && tbl_rank[i] < tbl_rank[best])))
            best = i;
        if (best >= 0) begin
          tbl_status[best] = ST_RUNNING;
          r.ok = 1; r.slot = 6'(best); r.pid = tbl_pid[best]; r.killed = tbl_killed[best];
        end
      end
      OP_YIELD, OP_SLEEP, OP_EXIT: begin
        if (tbl_status[s] == ST_RUNNING) begin
          if (op == OP_YIELD) begin
            if (tbl_prio[s] < PRIO_MAX) tbl_prio[s]++;
            tbl_status[s] = ST_RUNNABLE;
          end else if (op == OP_SLEEP) begin
            tbl_tag[s] = tag;
            tbl_status[s] = ST_SLEEPING;
          end else begin
            tbl_status[s] = ST_ZOMBIE;
          end
          close_gap(s);
          tbl_rank[s] = live_tasks - 1;
          r.ok = 1; r.slot = 6'(s); r.killed = tbl_killed[s];
        end
      end
      OP_WAKEUP: begin
        for (int i = 0; i < NSLOT; i++)
          if (i != s && tbl_status[i] == ST_SLEEPING && tbl_tag[i] == tag) begin
            tbl_status[i] = ST_RUNNABLE;
            r.ok = 1;
          end
      end
      OP_KILL: begin
        for (int i = 0; i < NSLOT; i++)
          if (tbl_status[i] != ST_FREE && tbl_pid[i] == tpid &&
              (best < 0 || tbl_rank[i] < tbl_rank[best]))
            best = i;
        if (best >= 0) begin
          tbl_killed[best] = 1;
          if (tbl_status[best] == ST_SLEEPING) tbl_status[best] = ST_RUNNABLE;
          r.ok = 1; r.slot = 6'(best); r.pid = tbl_pid[best]; r.killed = 1;
        end
      end
      default: begin
        if (tbl_status[s] != ST_FREE) begin
          r.killed = tbl_killed[s];
          close_gap(s);
          tbl_status[s] = ST_FREE;
          tbl_killed[s] = 0;
          tbl_prio[s] = 0;
          tbl_rank[s] = 0;
          live_tasks--;
          r.ok = 1; r.slot = 6'(s);
        end
      end
    endcase
    return r;
  endfunction

  // one transaction on the input channel; valid stays up between back-to-back items unless idle_en inserts a gap
  task automatic send_event(op_t op, int s = 0, bit [31:0] tag = 0, bit [30:0] tpid = 0);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_slot <= s[5:0];
    in_wait_tag <= tag;
    in_target_pid <= tpid;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(schedule_event(op, s, tag, tpid));
    op_hits[op]++;
    sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch on result %0d: %s got %0h expected %0h", checked, field, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    if (!rst_n || !stall_en) begin
      out_ready <= rst_n;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    sched_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("result with no transaction outstanding");
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_ok !== want.ok) report_mismatch("ok", out_ok, want.ok);
        if (out_result_slot !== want.slot) report_mismatch("slot", out_result_slot, want.slot);
        if (out_result_pid !== want.pid) report_mismatch("pid", out_result_pid, want.pid);
        if (out_killed_flag !== want.killed)
          report_mismatch("killed", out_killed_flag, want.killed);
      end
      checked++;
    end
  end

  function automatic int slot_in_state(tstat_t want);
    int hits[$];
    for (int i = 0; i < NSLOT; i++)
      if (tbl_status[i] == want) hits.push_back(i);
    if (hits.size() == 0) return $urandom_range(0, NSLOT - 1);
    return hits[$urandom_range(0, hits.size() - 1)];
  endfunction

  function automatic int live_slot();
    int hits[$];
    for (int i = 0; i < NSLOT; i++)
      if (tbl_status[i] != ST_FREE) hits.push_back(i);
    if (hits.size() == 0) return -1;
    return hits[$urandom_range(0, hits.size() - 1)];
  endfunction

  task automatic test_basic_ops();
    send_event(OP_PICK);                     // nothing runnable
    send_event(OP_REMOVE, 0);                // free slot
    send_event(OP_CREATE);
    send_event(OP_YIELD, 0);                 // not running yet
    send_event(OP_PICK);
    // demote until priority saturates
    for (int i = 0; i < 6; i++) begin
      send_event(OP_YIELD, 0);
      send_event(OP_PICK);
    end
    send_event(OP_CREATE);
    send_event(OP_CREATE);
    send_event(OP_PICK);                     // older of the two fresh tasks wins on rank
    send_event(OP_SLEEP, 1, 32'hFFFF_FFFF);
    send_event(OP_WAKEUP, 1, 32'hFFFF_FFFF); // caller excluded
    send_event(OP_WAKEUP, 63, 32'h0);        // tag mismatch
    send_event(OP_KILL, 0, 0, 31'd2);        // wakes the sleeper
    send_event(OP_KILL, 0, 0, 31'h7FFF_FFFF);
    send_event(OP_EXIT, 0);
    send_event(OP_REMOVE, 0);
  endtask

  task automatic test_table_full();
    for (int i = 0; i <= NSLOT; i++) send_event(OP_CREATE);
    for (int i = 0; i < NSLOT; i += 5) send_event(OP_REMOVE, i);
  endtask

  task automatic test_random(int count);
    int r, s;
    bit [30:0] p;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 12) send_event(OP_CREATE);
      else if (r < 30) send_event(OP_PICK);
      else if (r < 42) send_event(OP_YIELD, slot_in_state(ST_RUNNING));
      else if (r < 52)
        send_event(OP_SLEEP, slot_in_state(ST_RUNNING),
                   $urandom_range(0, 4) == 0 ? $urandom : tag_pool[$urandom_range(0, 3)]);
      else if (r < 62)
        send_event(OP_WAKEUP, $urandom_range(0, NSLOT - 1), tag_pool[$urandom_range(0, 3)]);
      else if (r < 70) begin
        s = live_slot();
        p = (s >= 0 && $urandom_range(0, 4) != 0) ? tbl_pid[s] : 31'($urandom);
        send_event(OP_KILL, 0, 0, p);
      end else if (r < 80) send_event(OP_EXIT, slot_in_state(ST_RUNNING));
      else if (r < 92)
        send_event(OP_REMOVE, $urandom_range(0, 2) == 0 ? live_slot() & 63
                                                       : slot_in_state(ST_ZOMBIE));
      else
        send_event(op_t'($urandom_range(0, 7)), $urandom_range(0, NSLOT - 1), $urandom,
                   31'($urandom));
    end
  endtask

  initial begin
    for (int i = 0; i < NSLOT; i++) begin
      tbl_status[i] = ST_FREE;
      tbl_prio[i] = 0;
      tbl_rank[i] = 0;
      tbl_pid[i] = 0;
      tbl_tag[i] = 0;
      tbl_killed[i] = 0;
    end
    live_tasks = 0;
    pid_counter = 31'd1;
    tag_pool = '{32'h0, 32'hFFFF_FFFF, 32'hA5A5_5A5A, $urandom};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_ops();
    test_table_full();
    idle_en = 1'b1;
    stall_en = 1'b1;
    test_random(110);
    wait_drained();                          // sender holds off until all results are in
    test_random(110);
    idle_en = 1'b0;
    stall_en = 1'b0;
    test_random(80);
    wait_drained();

    $display("%0d events sent (create %0d pick %0d yield %0d sleep %0d wakeup %0d",
             sent, op_hits[0], op_hits[1], op_hits[2], op_hits[3], op_hits[4]);
    $display("kill %0d exit %0d remove %0d), %0d results compared, %0d mismatches",
             op_hits[5], op_hits[6], op_hits[7], checked, errors);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("** priority_fcfs_task_scheduler: PASSED **");
    end else begin
      $display("** priority_fcfs_task_scheduler: FAILED **");
    end
    $finish;
  end

  initial begin
    #(20 * 2_000_000);
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("** priority_fcfs_task_scheduler: FAILED **");
    $finish;
  end
endmodule
`default_nettype wire
